[design/rank_morphological_gradient_macros.svh]
// Assertion macros used by the checker file of the rank gradient block.
`ifndef RANK_MORPHOLOGICAL_GRADIENT_MACROS_SVH
`define RANK_MORPHOLOGICAL_GRADIENT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RMG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RMG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rmg_pkg.sv]
// Shared types and constants of the rank morphological gradient block.
package rmg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int SHAPE_W     = 25;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHAPE_BITS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_RANK    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASK_ENABLE   = 3'd4;

    typedef struct packed {
        logic [7:0] pixel;
        logic       mask_bit;
    } t_in;

    typedef struct packed {
        logic [7:0] gradient;
        logic       end_of_image;
    } t_out;

    // Per-beat control carried along the pipeline.
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } t_ctl;

endpackage

[design/rank_morphological_gradient.sv]
// Top level of the rank morphological gradient block.
//
// Usage: pixels enter column by column on the input channel (i_in_valid,
// o_in_stall, i_in_data), one beat per pixel with its mask bit. For every
// position where the full window fits, one beat leaves on the output channel
// (o_out_valid, i_out_stall, o_out_data): the gradient between the upper and
// lower rank of the shaped window around the center, with end_of_image set on
// the last result of an image. Positions without a full window give no beat.
// Throughput: one pixel per cycle while the output queue is not full.
// The pipeline is a memory read of the row, a window shift, a comparison
// stage, a position count stage and a pick-and-subtract stage, followed by
// the output queue.
// Write configuration only while the block is idle; writes take effect at once.
// Reset (i_rst_n low at a clock edge) clears the positions, the pipeline and
// the output queue and loads the register defaults; the column memory is not
// cleared. When the receiver stalls, results collect in a two-entry queue and
// the block keeps taking pixels until the queue is full; then o_in_stall rises
// and the whole pipeline holds.
module rank_morphological_gradient #(
    parameter int HALF_ROWS         = 2,
    parameter int HALF_COLS         = 2,
    parameter int MAX_COLUMN_LENGTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rmg_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rmg_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [rmg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rmg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rmg_pkg::*;

    localparam int WR = 2*HALF_ROWS + 1;
    localparam int WC = 2*HALF_COLS + 1;
    localparam int WS = WR*WC;
    localparam int RW = $clog2(MAX_COLUMN_LENGTH);
    localparam int LW = $clog2(MAX_COLUMN_LENGTH + 1);

    // Configuration registers
    logic [10:0]        r_cfg_len;
    logic [15:0]        r_cfg_cnt;
    logic [SHAPE_W-1:0] r_cfg_shape;
    logic [3:0]         r_cfg_depth;
    logic               r_cfg_mask_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len     <= 11'd1024;
            r_cfg_cnt     <= 16'd5;
            r_cfg_shape   <= '1;
            r_cfg_depth   <= 4'd0;
            r_cfg_mask_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMN_LENGTH: r_cfg_len     <= i_cfg_data[10:0];
                CFG_COLUMN_COUNT:  r_cfg_cnt     <= i_cfg_data[15:0];
                CFG_SHAPE_BITS:    r_cfg_shape   <= i_cfg_data[SHAPE_W-1:0];
                CFG_DEPTH_RANK:    r_cfg_depth   <= i_cfg_data[3:0];
                CFG_MASK_ENABLE:   r_cfg_mask_en <= i_cfg_data[0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // Saturate the image size into the usable range.
    logic [LW-1:0] eff_len;
    logic [15:0]   eff_cnt;

    always_comb begin
        if (32'(r_cfg_len) < 32'(WR)) begin
            eff_len = LW'(WR);
        end else if (32'(r_cfg_len) > 32'(MAX_COLUMN_LENGTH)) begin
            eff_len = LW'(MAX_COLUMN_LENGTH);
        end else begin
            eff_len = LW'(32'(r_cfg_len));
        end
        eff_cnt = (32'(r_cfg_cnt) < 32'(WC)) ? 16'(WC) : r_cfg_cnt;
    end

    // Input position tracking
    logic          adv, accept, q_full, row_last, col_last;
    logic [RW-1:0] r_row;
    logic [15:0]   r_col;
    t_ctl          in_ctl;

    assign adv        = !q_full;
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && adv;

    assign row_last = (32'(r_row) + 32'd1) >= 32'(eff_len);
    assign col_last = (32'(r_col) + 32'd1) >= 32'(eff_cnt);

    assign in_ctl.valid = accept;
    assign in_ctl.emit  = (32'(r_row) >= 32'(2*HALF_ROWS)) && (32'(r_col) >= 32'(2*HALF_COLS));
    assign in_ctl.last  = row_last && col_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (row_last) begin
                r_row <= '0;
                r_col <= col_last ? 16'd0 : r_col + 16'd1;  // wrap starts a new image
            end else begin
                r_row <= r_row + RW'(1);
            end
        end
    end

    // Column memory and window
    t_in  win [WS];
    t_ctl win_ctl;

    rmg_line_store #(
        .HALF_ROWS         (HALF_ROWS),
        .HALF_COLS         (HALF_COLS),
        .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_row   (r_row),
        .i_item  (i_in_data),
        .i_ctl   (in_ctl),
        .o_win   (win),
        .o_ctl   (win_ctl)
    );

    // Rank pipeline
    logic rank_valid;
    t_out rank_res;

    rmg_rank #(
        .HALF_ROWS (HALF_ROWS),
        .HALF_COLS (HALF_COLS)
    ) u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_win     (win),
        .i_ctl     (win_ctl),
        .i_shape   (r_cfg_shape),
        .i_depth   (r_cfg_depth),
        .i_mask_en (r_cfg_mask_en),
        .o_valid   (rank_valid),
        .o_res     (rank_res)
    );

    // Push the finished beat only when the pipeline advances.
    rmg_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rank_valid && adv),
        .i_data  (rank_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_full  (q_full)
    );

endmodule

[design/rmg_line_store.sv]
// Column store memory and window registers of the rank gradient block.
module rmg_line_store #(
    parameter int HALF_ROWS         = 2,
    parameter int HALF_COLS         = 2,
    parameter int MAX_COLUMN_LENGTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic [$clog2(MAX_COLUMN_LENGTH)-1:0] i_row,
    input  rmg_pkg::t_in                         i_item,
    input  rmg_pkg::t_ctl                        i_ctl,
    output rmg_pkg::t_in                         o_win [(2*HALF_ROWS+1)*(2*HALF_COLS+1)],
    output rmg_pkg::t_ctl                        o_ctl
);
    import rmg_pkg::*;

    localparam int WR = 2*HALF_ROWS + 1;
    localparam int WC = 2*HALF_COLS + 1;
    localparam int RW = $clog2(MAX_COLUMN_LENGTH);

    // Each entry holds the last WC-1 columns at one row, oldest first.
    t_in [WC-2:0] mem [MAX_COLUMN_LENGTH];
    t_in [WC-2:0] r_rdata;
    logic [RW-1:0] r_row;
    t_in           r_item;
    t_ctl          r_ctl;
    t_ctl          r_wctl;
    t_in [WC-1:0]  r_win [WR];
    t_in [WC-1:0]  row_vec;

    always_comb begin
        for (int c = 0; c < WC-1; c++) begin
            row_vec[c] = r_rdata[c];
        end
        row_vec[WC-1] = r_item;
    end

    // Read on accept, write the shifted row back when the registered beat advances.
    always_ff @(posedge i_clk) begin
        if (i_adv && r_ctl.valid) begin
            mem[r_row] <= row_vec[WC-1:1];
        end
        if (i_adv && i_ctl.valid) begin
            r_rdata <= mem[i_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_row  <= i_row;
            r_item <= i_item;
            if (r_ctl.valid) begin
                for (int rr = 0; rr < WR-1; rr++) begin
                    r_win[rr] <= r_win[rr+1];
                end
                r_win[WR-1] <= row_vec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_wctl <= '0;
        end else if (i_adv) begin
            r_ctl       <= i_ctl;
            r_wctl.valid <= r_ctl.valid && r_ctl.emit;
            r_wctl.emit  <= r_ctl.emit;
            r_wctl.last  <= r_ctl.last;
        end
    end

    always_comb begin
        for (int c = 0; c < WC; c++) begin
            for (int rr = 0; rr < WR; rr++) begin
                o_win[c*WR + rr] = r_win[rr][c];
            end
        end
    end

    assign o_ctl = r_wctl;

endmodule

[design/rmg_rank.sv]
// Rank selection pipeline: compare, count positions, pick and subtract.
module rmg_rank #(
    parameter int HALF_ROWS = 2,
    parameter int HALF_COLS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  rmg_pkg::t_in                  i_win [(2*HALF_ROWS+1)*(2*HALF_COLS+1)],
    input  rmg_pkg::t_ctl                 i_ctl,
    input  logic [rmg_pkg::SHAPE_W-1:0]   i_shape,
    input  logic [3:0]                    i_depth,
    input  logic                          i_mask_en,
    output logic                          o_valid,
    output rmg_pkg::t_out                 o_res
);
    import rmg_pkg::*;

    localparam int WR     = 2*HALF_ROWS + 1;
    localparam int WS     = WR*(2*HALF_COLS + 1);
    localparam int PW     = $clog2(WS + 1);
    localparam int CENTER = HALF_COLS*WR + HALF_ROWS;

    logic [WS-1:0] sel;
    logic [WS-1:0] lt [WS];
    logic [PW-1:0] n_cnt;

    for (genvar i = 0; i < WS; i++) begin : g_sel
        if (i < SHAPE_W) begin : g_in
            assign sel[i] = i_shape[i];
        end else begin : g_out
            assign sel[i] = 1'b0;
        end
        // Ties break by window order so every selected value gets its own position.
        for (genvar j = 0; j < WS; j++) begin : g_cmp
            assign lt[i][j] = sel[j] && ((i_win[j].pixel < i_win[i].pixel) ||
                              ((i_win[j].pixel == i_win[i].pixel) && (j < i)));
        end
    end

    always_comb begin
        n_cnt = '0;
        for (int i = 0; i < WS; i++) begin
            n_cnt = n_cnt + PW'(sel[i]);
        end
    end

    // Stage 2: comparison matrix
    logic          r2_valid, r2_last, r2_gate;
    logic [WS-1:0] r2_lt [WS];
    logic [WS-1:0] r2_sel;
    logic [7:0]    r2_v [WS];
    logic [PW-1:0] r2_n;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_lt   <= lt;
            r2_sel  <= sel;
            r2_n    <= n_cnt;
            r2_last <= i_ctl.last;
            r2_gate <= !(i_mask_en && !i_win[CENTER].mask_bit);
            for (int i = 0; i < WS; i++) begin
                r2_v[i] <= i_win[i].pixel;
            end
        end
    end

    // Stage 3: positions and rank bounds
    logic [PW-1:0] pos [WS];
    logic [7:0]    half8, lo8, hi8;

    always_comb begin
        for (int i = 0; i < WS; i++) begin
            pos[i] = '0;
            for (int j = 0; j < WS; j++) begin
                pos[i] = pos[i] + PW'(r2_lt[i][j]);
            end
        end
        half8 = 8'(r2_n - PW'(1)) >> 1;
        lo8   = (8'(i_depth) > half8) ? half8 : 8'(i_depth);
        hi8   = 8'(r2_n) - 8'd1 - lo8;
    end

    logic          r3_valid, r3_last, r3_gate;
    logic [PW-1:0] r3_pos [WS];
    logic [WS-1:0] r3_sel;
    logic [7:0]    r3_v [WS];
    logic [PW-1:0] r3_lo, r3_hi;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_pos  <= pos;
            r3_sel  <= r2_sel;
            r3_v    <= r2_v;
            r3_lo   <= PW'(lo8);
            r3_hi   <= PW'(hi8);
            r3_last <= r2_last;
            r3_gate <= r2_gate && (r2_n != '0);
        end
    end

    // Stage 4: pick both ranks and subtract
    logic [7:0] v_lo, v_hi;

    always_comb begin
        v_lo = '0;
        v_hi = '0;
        for (int i = 0; i < WS; i++) begin
            if (r3_sel[i] && (r3_pos[i] == r3_lo)) begin
                v_lo = v_lo | r3_v[i];
            end
            if (r3_sel[i] && (r3_pos[i] == r3_hi)) begin
                v_hi = v_hi | r3_v[i];
            end
        end
    end

    logic r4_valid;
    t_out r4_res;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_res.gradient     <= r3_gate ? (v_hi - v_lo) : 8'd0;
            r4_res.end_of_image <= r3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= i_ctl.valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    assign o_valid = r4_valid;
    assign o_res   = r4_res;

endmodule

[design/rmg_out_queue.sv]
// Two-entry output queue that decouples the pipeline from a stalled receiver.
module rmg_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rmg_pkg::t_out i_data,
    input  logic          i_stall,
    output logic          o_valid,
    output rmg_pkg::t_out o_data,
    output logic          o_full
);
    import rmg_pkg::*;

    t_out       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign o_full  = (r_cnt == 2'd2);

endmodule

[design/rmg_checker.sv]
// Port-level checker of the rank gradient block and its bind.
`include "rank_morphological_gradient_macros.svh"

module rmg_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input rmg_pkg::t_out o_out_data
);
    import rmg_pkg::*;

    `RMG_ASSERT_NOW(a_stall_needs_backpressure, o_in_stall, $past(i_out_stall), "input stalled without output backpressure")
    `RMG_ASSERT_NEXT(a_pop_frees_input, o_out_valid && !i_out_stall, !o_in_stall, "input still stalled after an output beat")
    `RMG_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output beat changed")

endmodule

bind rank_morphological_gradient rmg_checker u_rmg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
